// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_PUSH    = 3;

   localparam logic [3:0] PREFIX_SKIP_RESET = 4'd2;

   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_TWO   = 2'd2;
   localparam logic [1:0] FILL_THREE = 2'd3;

   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sextet_type;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } entry_type;

   // up to three bytes produced by one input transaction, byte 0 goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } push_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.ok  = 1'b1;
      r.val = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r.val = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r.val = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.val = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         r.val = 6'd62;
      end else if (c == 8'h2f) begin
         r.val = 6'd63;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // a partial group of n characters gives n-1 bytes
   function automatic push_type flush_of(input logic [1:0] fill, input logic [17:0] acc);
      push_type p;
      p.count = 2'd0;
      p.bytes = '0;
      if (fill == FILL_TWO) begin
         p.count    = 2'd1;
         p.bytes[0] = acc[11:4];
      end else if (fill == FILL_THREE) begin
         p.count    = 2'd2;
         p.bytes[0] = acc[17:10];
         p.bytes[1] = acc[9:2];
      end
      return p;
   endfunction

endpackage

// ===== sv/b64d_core.sv =====
module b64d_core import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic       fire,
   input  logic [7:0] text_char,
   input  logic       end_of_text,
   output push_type   push
);

   logic [3:0]  prefix_skip_ff;
   logic [3:0]  skip_left_ff, skip_left_in;
   logic [1:0]  fill_ff, fill_in;
   logic [17:0] acc_ff, acc_in;
   logic        halted_ff, halted_in;
   sextet_type  sx;
   push_type    emit;
   logic [23:0] word;

   assign sx = sextet_of(text_char);

   // full group: 24 bits from accumulator and the new sextet
   assign word = {acc_ff, sx.val};

   always_comb begin
      skip_left_in = skip_left_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      halted_in    = halted_ff;
      emit         = '0;

      if (skip_left_ff != 4'd0) begin
         skip_left_in = skip_left_ff - 4'd1;
      end else if (!halted_ff) begin
         if (!sx.ok) begin
            halted_in = 1'b1;
            emit      = flush_of(fill_ff, acc_ff);
            fill_in   = FILL_EMPTY;
            acc_in    = '0;
         end else if (fill_ff == FILL_THREE) begin
            emit.count    = 2'd3;
            emit.bytes[0] = word[23:16];
            emit.bytes[1] = word[15:8];
            emit.bytes[2] = word[7:0];
            fill_in       = FILL_EMPTY;
            acc_in        = '0;
         end else begin
            acc_in  = {acc_ff[11:0], sx.val};
            fill_in = fill_ff + 2'd1;
         end
      end

      if (end_of_text) begin
         // only the accumulate path can leave bytes pending here
         if (!halted_in && fill_in != FILL_EMPTY) begin
            emit = flush_of(fill_in, acc_in);
         end
         skip_left_in = prefix_skip_ff;
         fill_in      = FILL_EMPTY;
         acc_in       = '0;
         halted_in    = 1'b0;
      end
   end

   assign push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_skip_ff <= PREFIX_SKIP_RESET;
         skip_left_ff   <= PREFIX_SKIP_RESET;
         fill_ff        <= FILL_EMPTY;
         acc_ff         <= '0;
         halted_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            prefix_skip_ff <= csr_wr_data;
         end
         if (fire) begin
            skip_left_ff <= skip_left_in;
            fill_ff      <= fill_in;
            acc_ff       <= acc_in;
            halted_ff    <= halted_in;
         end
      end
   end

endmodule

// ===== sv/b64d_outq.sv =====
module b64d_outq import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  push_type   push,
   output logic       has_room,
   output logic       out_valid,
   input  logic       out_ready,
   output entry_type  out_entry
);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       n_push;
   logic             pop;

   assign n_push    = push_en ? push.count : 2'd0;
   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   // room for a full group, judged on the registered fill level
   assign has_room  = count_ff <= CNT_W'(QUEUE_DEPTH - MAX_PUSH);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
   assign count_in  = count_ff + CNT_W'(n_push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < n_push) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)].data <= push.bytes[i];
            mem_ff[wr_ptr_ff + PTR_W'(i)].last <= (2'(i + 1) == n_push);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

// ===== sv/base64_stream_decoder.sv =====
// Streaming base64 decoder, one character per transaction.
// Decoded bytes enter the output queue as their character is accepted, in order.
// Throughput: one character per cycle; with rsp_ready high, bytes leave one per cycle
// through an eight-entry queue; req_ready drops while fewer than three entries are free.
// Reset (synchronous, active high): prefix_skip returns to 2, the decoder rearms and
// the output queue empties.
module base64_stream_decoder import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_run
);

   logic      fire;
   push_type  push;
   entry_type head;

   assign fire = req_valid && req_ready;

   b64d_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .text_char   (req_text_char),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   b64d_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_en   (fire),
      .push      (push),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_entry (head)
   );

   assign rsp_data_byte   = head.data;
   assign rsp_last_of_run = head.last;

endmodule
